// ===== rtl/bmhq_pkg.sv =====
// Package for the binary max-heap priority queue.
// Request and status codes, the compare select and data width; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int unsigned DataW = 32;

  // Request codes; the fourth code is a no-op
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [DataW-1:0] EMPTY_VALUE = -32'sd1;

  // Operand selection for the shared comparator
  typedef enum logic [1:0] {
    CMP_RISE  = 2'd0,  // parent < moving value
    CMP_CHILD = 2'd1,  // left child < right child
    CMP_SINK  = 2'd2   // moving value < larger child
  } cmp_sel_e;

endpackage

`default_nettype wire

// ===== rtl/binary_max_heap_queue.sv =====
// Max-priority queue of signed 32-bit values held as an array binary heap in one RAM of
// DEPTH entries. Each request (insert, pop, peek) gives one result. A sequencer walks the
// heap one level at a time through a single RAM read port and one shared comparator. An
// insert moves its value up and a pop moves the last entry down from the root, each by at
// most log2(DEPTH) levels. The input is not ready while a request is worked on, and a
// result that finds the output register still occupied holds the sequencer until it is
// taken; a finished result waits in the output register while the next request is taken.
// No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic        [1:0]                      req_type_i,
  input  wire logic signed [bmhq_pkg::DataW-1:0]      value_in_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed      [bmhq_pkg::DataW-1:0]      value_out_o,
  output logic             [1:0]                      status_o,
  output logic             [10:0]                     fill_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_ROOT_RD   = 11'b00000000010,
    S_ROOT_WAIT = 11'b00000000100,
    S_LAST_WAIT = 11'b00000001000,
    S_DN_CHK    = 11'b00000010000,
    S_DN_LEFT   = 11'b00000100000,
    S_DN_RIGHT  = 11'b00001000000,
    S_DN_CMP    = 11'b00010000000,
    S_UP_CHK    = 11'b00100000000,
    S_UP_CMP    = 11'b01000000000,
    S_DONE      = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0]                        req_q, req_d;
  logic signed [bmhq_pkg::DataW-1:0] val_q, val_d;
  logic signed [bmhq_pkg::DataW-1:0] lval_q, lval_d;
  logic signed [bmhq_pkg::DataW-1:0] pval_q, pval_d;
  logic [AW-1:0]                     at_q, at_d;
  logic [AW-1:0]                     pick_q, pick_d;
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic signed [bmhq_pkg::DataW-1:0] res_q, res_d;
  logic [1:0]                        st_q, st_d;
  logic                              out_valid_q, out_valid_d;
  logic signed [bmhq_pkg::DataW-1:0] out_val_q, out_val_d;
  logic [1:0]                        out_st_q, out_st_d;
  logic [10:0]                       out_fill_q, out_fill_d;

  logic                              ram_we, ram_re;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  logic signed [bmhq_pkg::DataW-1:0] ram_wdata;
  logic [bmhq_pkg::DataW-1:0]        ram_rdata_raw;
  logic signed [bmhq_pkg::DataW-1:0] ram_rdata;

  bmhq_pkg::cmp_sel_e                cmp_sel;
  logic                              cmp_lt;

  logic [AW+1:0]                     l_w, r_w, n_w;
  logic [AW-1:0]                     up_idx;
  logic [CW+10:0]                    cnt_wide;
  logic                              in_xfer;

  assign ram_rdata = $signed(ram_rdata_raw);
  assign l_w       = {1'b0, at_q, 1'b1};
  assign r_w       = l_w + (AW+2)'(1);
  assign n_w       = (AW+2)'(cnt_q);
  assign up_idx    = (at_q - AW'(1)) >> 1;
  assign cnt_wide  = (CW+11)'(cnt_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  bmhq_ram #(
    .WIDTH(bmhq_pkg::DataW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  bmhq_cmp u_cmp (
    .sel_i  (cmp_sel),
    .val_i  (val_q),
    .rdata_i(ram_rdata),
    .lval_i (lval_q),
    .pval_i (pval_q),
    .lt_o   (cmp_lt)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    val_d       = val_q;
    lval_d      = lval_q;
    pval_d      = pval_q;
    at_d        = at_q;
    pick_d      = pick_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_fill_d  = out_fill_q;
    ram_we      = 1'b0;
    ram_waddr   = at_q;
    ram_wdata   = val_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    cmp_sel     = bmhq_pkg::CMP_RISE;

    // drop the result once transferred
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d = req_type_i;
          val_d = value_in_i;
          res_d = '0;
          st_d  = bmhq_pkg::ST_OK;
          priority if (req_type_i == bmhq_pkg::REQ_INSERT) begin
            if (cnt_q == CW'(DEPTH)) begin
              st_d    = bmhq_pkg::ST_FULL;
              state_d = S_DONE;
            end else begin
              at_d    = AW'(cnt_q);
              cnt_d   = cnt_q + CW'(1);
              state_d = S_UP_CHK;
            end
          end else if (req_type_i == bmhq_pkg::REQ_POP ||
                       req_type_i == bmhq_pkg::REQ_PEEK) begin
            if (cnt_q == '0) begin
              res_d   = bmhq_pkg::EMPTY_VALUE;
              st_d    = bmhq_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else begin
              state_d = S_ROOT_RD;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ROOT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        res_d = ram_rdata;
        if (req_q == bmhq_pkg::REQ_POP) begin
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = S_DONE;
          end else begin
            // fetch the last entry; it sinks from the root
            ram_re    = 1'b1;
            ram_raddr = AW'(cnt_q - CW'(1));
            at_d      = '0;
            state_d   = S_LAST_WAIT;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_LAST_WAIT: begin
        val_d   = ram_rdata;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (l_w >= n_w) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(l_w);
          state_d   = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        lval_d = ram_rdata;
        pval_d = ram_rdata;
        pick_d = AW'(l_w);
        if (r_w < n_w) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(r_w);
          state_d   = S_DN_RIGHT;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_RIGHT: begin
        // left wins a tie
        cmp_sel = bmhq_pkg::CMP_CHILD;
        if (cmp_lt) begin
          pval_d = ram_rdata;
          pick_d = AW'(r_w);
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmp_sel = bmhq_pkg::CMP_SINK;
        ram_we  = 1'b1;
        if (cmp_lt) begin
          ram_wdata = pval_q;
          at_d      = pick_q;
          state_d   = S_DN_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP_CHK: begin
        if (at_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = up_idx;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_sel = bmhq_pkg::CMP_RISE;
        ram_we  = 1'b1;
        if (cmp_lt) begin
          // move the parent down into the hole
          ram_wdata = ram_rdata;
          at_d      = up_idx;
          state_d   = S_UP_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_q;
          out_st_d    = st_q;
          out_fill_d  = cnt_wide[10:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    val_q      <= val_d;
    lval_q     <= lval_d;
    pval_q     <= pval_d;
    at_q       <= at_d;
    pick_q     <= pick_d;
    res_q      <= res_d;
    st_q       <= st_d;
    out_val_q  <= out_val_d;
    out_st_q   <= out_st_d;
    out_fill_q <= out_fill_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_out_o  = out_val_q;
  assign status_o     = out_st_q;
  assign fill_count_o = out_fill_q;

  // The entry count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  // The store is written only while an entry settles
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_UP_CHK || state_q == S_UP_CMP ||
                state_q == S_DN_CHK || state_q == S_DN_CMP))
    else $error("heap store written outside a sift");

  // An empty result carries the empty marker and a zero fill count
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bmhq_pkg::ST_EMPTY) |->
      (value_out_o == bmhq_pkg::EMPTY_VALUE && fill_count_o == 11'd0))
    else $error("empty status with wrong value or fill count");

  // With the sequencer idle and no request offered, the count stays unchanged
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_valid_i) |=> $stable(cnt_q))
    else $error("entry count changed without a request");

endmodule

`default_nettype wire

// ===== rtl/bmhq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the heap store.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bmhq_cmp.sv =====
// Shared signed comparator of the heap sequencer with its operand selection.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_cmp (
  input  wire bmhq_pkg::cmp_sel_e                     sel_i,
  input  wire logic signed [bmhq_pkg::DataW-1:0]      val_i,
  input  wire logic signed [bmhq_pkg::DataW-1:0]      rdata_i,
  input  wire logic signed [bmhq_pkg::DataW-1:0]      lval_i,
  input  wire logic signed [bmhq_pkg::DataW-1:0]      pval_i,
  output logic                                        lt_o
);

  logic signed [bmhq_pkg::DataW-1:0] a;
  logic signed [bmhq_pkg::DataW-1:0] b;

  always_comb begin
    unique case (sel_i)
      bmhq_pkg::CMP_RISE: begin
        a = rdata_i;
        b = val_i;
      end
      bmhq_pkg::CMP_CHILD: begin
        a = lval_i;
        b = rdata_i;
      end
      bmhq_pkg::CMP_SINK: begin
        a = val_i;
        b = pval_i;
      end
      default: begin
        a = val_i;
        b = val_i;
      end
    endcase
  end

  assign lt_o = (a < b);

endmodule

`default_nettype wire
